// File: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with delete.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int OPCODE_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int POPPED_W  = 32;
    localparam int ENTRIES_W = 7;
    localparam int STATUS_W  = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_DELETE     = 3'd4,
        OP_COUNT      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESULT,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

// File: rtl/core/bdq_stream_if.sv
// ----------------------------------------------------------------------------
// bdq_cmd_if / bdq_rsp_if
// Valid/ready channels for deque commands and responses.
// ----------------------------------------------------------------------------
interface bdq_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [bdq_pkg::OPCODE_W-1:0]   opcode;
    logic [bdq_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bdq_pkg::POPPED_W-1:0]   popped;
    logic [bdq_pkg::ENTRIES_W-1:0]  entries;
    logic [bdq_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output popped, output entries, output status, input ready);
    modport sink   (input valid, input popped, input entries, input status, output ready);
endinterface

// File: rtl/core/bounded_deque_with_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_delete
// Bounded double-ended queue in a ring-buffer RAM, with delete by value.
//
// i_cmd carries one operation per transfer (opcode, value); o_rsp returns
// exactly one response per command (popped, entries, status), in order.
// Push, pop, count: the RAM access is issued in the accept cycle, and the
// response is loaded into the output register from the result step, so a
// new command is taken only once the last one is through. Delete walks the
// RAM one entry per cycle from the front (compare), then moves each later
// entry down one place (one read and one write per cycle). The single RAM
// read port sets this pace.
// Commands are taken whenever the sequencer is idle, even while a response
// waits in the output register; if the receiver stalls, the next command
// holds in its final step until the output register frees up.
// Reset empties the queue (front 0, count 0) and drops any pending response;
// RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdq_cmd_if.sink    i_cmd,
    bdq_rsp_if.source  o_rsp
);
    import bdq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   CAP_W   = (CW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_IX = AW'(CAPACITY - 1);

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
        if (s >= CAP_W) begin
            s = s - CAP_W;
        end
        return s[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_occ, n_occ;
    logic [CW-1:0]         r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    t_status               r_status, n_status;
    logic                  r_pop_sel, n_pop_sel;

    logic                  r_out_valid, n_out_valid;
    logic [POPPED_W-1:0]   r_out_popped, n_out_popped;
    logic [ENTRIES_W-1:0]  r_out_entries, n_out_entries;
    t_status               r_out_status, n_out_status;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                  in_fire, slot_free, is_full, is_empty;
    logic                  scan_hit, scan_last, shift_more;
    logic [DATA_WIDTH-1:0] in_val;
    logic [CW-1:0]         idx_p1, idx_p2;
    logic [AW-1:0]         front_dec;
    t_op                   in_op;

    assign in_op     = t_op'(i_cmd.opcode);
    assign in_val    = DATA_WIDTH'(i_cmd.value);
    assign in_fire   = i_cmd.valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign is_full   = ({1'b0, r_occ} >= CAP_W);
    assign is_empty  = (r_occ == '0);
    assign idx_p1    = r_idx + CW'(1);
    assign idx_p2    = r_idx + CW'(2);
    assign scan_hit  = (ram_rdata == r_val);
    assign scan_last = (idx_p1 == r_occ);
    assign shift_more = ({1'b0, r_idx} + (CW+1)'(2)) < {1'b0, r_occ};
    assign front_dec = (r_front == '0) ? LAST_IX : r_front - AW'(1);

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.popped  = r_out_popped;
    assign o_rsp.entries = r_out_entries;
    assign o_rsp.status  = r_out_status;

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (in_op == OP_DELETE && !is_empty) ? S_SCAN : S_RESULT;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = scan_last ? S_RESULT : S_SHIFT;
                end else if (scan_last) begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    n_state = S_RESULT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = r_front;
        ram_wdata     = r_val;
        ram_re        = 1'b0;
        ram_raddr     = r_front;
        n_front       = r_front;
        n_occ         = r_occ;
        n_idx         = r_idx;
        n_val         = r_val;
        n_status      = r_status;
        n_pop_sel     = r_pop_sel;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_popped  = r_out_popped;
        n_out_entries = r_out_entries;
        n_out_status  = r_out_status;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_val     = in_val;
                    n_pop_sel = 1'b0;
                    n_status  = ST_OK;
                    n_idx     = '0;
                    unique case (in_op)
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = ring_pos(r_front, r_occ);
                                ram_wdata = in_val;
                                n_occ     = r_occ + CW'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = ring_pos(r_front, r_occ - CW'(1));
                                n_pop_sel = 1'b1;
                                n_occ     = r_occ - CW'(1);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = front_dec;
                                ram_wdata = in_val;
                                n_front   = front_dec;
                                n_occ     = r_occ + CW'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_front;
                                n_pop_sel = 1'b1;
                                n_front   = ring_pos(r_front, CW'(1));
                                n_occ     = r_occ - CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_front;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_popped  = r_pop_sel ? POPPED_W'(ram_rdata) : '0;
                    n_out_entries = ENTRIES_W'(r_occ);
                    n_out_status  = r_status;
                end
            end
            S_SCAN: begin
                // read data holds the entry at r_idx; prefetch the next one
                if (scan_hit) begin
                    if (scan_last) begin
                        n_occ = r_occ - CW'(1);
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ring_pos(r_front, idx_p1);
                    end
                end else if (scan_last) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(r_front, idx_p1);
                    n_idx     = idx_p1;
                end
            end
            S_SHIFT: begin
                // read data holds the entry at r_idx + 1
                ram_we    = 1'b1;
                ram_waddr = ring_pos(r_front, r_idx);
                ram_wdata = ram_rdata;
                if (shift_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_pos(r_front, idx_p2);
                    n_idx     = idx_p1;
                end else begin
                    n_occ = r_occ - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_val         <= n_val;
        r_status      <= n_status;
        r_pop_sel     <= n_pop_sel;
        r_out_popped  <= n_out_popped;
        r_out_entries <= n_out_entries;
        r_out_status  <= n_out_status;
    end

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_occ} <= CAP_W)
        else $error("occupancy above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {{(CW+1-AW){1'b0}}, r_front} < CAP_W)
        else $error("front index out of range");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("RAM read and write to the same entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a command transfer");

    a_rsp_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> (r_state == S_RESULT))
        else $error("response loaded outside the result step");
`endif

endmodule

// File: rtl/core/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM, one write and one read port, registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
